// ----- hdl/odo_pkg.sv -----
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, constants and helpers for the arc odometry pose core.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam logic signed [33:0] TURN_K      = 34'sd683565276;
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;
  localparam logic [29:0]        EIGHTH_TURN = 30'h2000_0000;
  localparam int                 DIV_STEPS   = 48;

  typedef enum logic [0:0] {
    CFG_FWD_OFFSET  = 1'b0,
    CFG_SIDE_OFFSET = 1'b1
  } odo_cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP,
    ST_SC_PHASE,
    ST_SC_X,
    ST_SC_X2,
    ST_SC_TERM,
    ST_SC_RECIP,
    ST_SC_CORR,
    ST_SC_ACC,
    ST_SC_END,
    ST_DIV,
    ST_CH_U,
    ST_CH_L,
    ST_ROT1,
    ST_ROT2,
    ST_ROT3,
    ST_ROT4,
    ST_ROT5,
    ST_ROT6,
    ST_DONE
  } odo_state_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // Series divisor for each term: sine terms first, then cosine terms.
  function automatic logic [6:0] term_div(input logic [2:0] term);
    case (term)
      3'd0:    return 7'd6;
      3'd1:    return 7'd20;
      3'd2:    return 7'd42;
      3'd3:    return 7'd72;
      3'd4:    return 7'd2;
      3'd5:    return 7'd12;
      3'd6:    return 7'd30;
      default: return 7'd56;
    endcase
  endfunction

  // floor(2^32 / term_div)
  function automatic logic [31:0] term_recip(input logic [2:0] term);
    case (term)
      3'd0:    return 32'd715827882;
      3'd1:    return 32'd214748364;
      3'd2:    return 32'd102261126;
      3'd3:    return 32'd59652323;
      3'd4:    return 32'd2147483648;
      3'd5:    return 32'd357913941;
      3'd6:    return 32'd143165576;
      default: return 32'd76695844;
    endcase
  endfunction

endpackage

// ----- hdl/odo_div.sv -----
// ----------------------------------------------------------------------------
// odo_div
// Radix-2 restoring divider: sat32(trunc(num * 2^16 / den)), one bit a cycle.
// ----------------------------------------------------------------------------
module odo_div
  import odo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quo
);

  logic        busy;
  logic        fin;
  logic [5:0]  cnt;
  logic [32:0] rem;
  logic [47:0] qn;
  logic [31:0] dmag;
  logic        neg;
  logic [31:0] num_mag;
  logic [32:0] rem_sh;
  logic        ge;

  assign num_mag = num[31] ? 32'(-num) : 32'(num);
  assign rem_sh  = {rem[31:0], qn[47]};
  assign ge      = rem_sh >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt  <= '0;
      rem  <= '0;
      qn   <= {num_mag, 16'h0000};
      dmag <= den[31] ? 32'(-den) : 32'(den);
      neg  <= num[31] ^ den[31];
    end else if (busy) begin
      cnt <= cnt + 6'd1;
      rem <= ge ? rem_sh - {1'b0, dmag} : rem_sh;
      qn  <= {qn[46:0], ge};
    end
  end

  always_comb begin
    if (neg) begin
      if ((|qn[47:32]) || (qn[31] && (|qn[30:0]))) begin
        quo = 32'sh8000_0000;
      end else begin
        quo = 32'(-qn[31:0]);
      end
    end else begin
      if (|qn[47:31]) begin
        quo = 32'sh7fff_ffff;
      end else begin
        quo = qn[31:0];
      end
    end
  end

  assign done = fin;

endmodule

// ----- hdl/arc_odometry_pose_update_core.sv -----
// ----------------------------------------------------------------------------
// arc_odometry_pose_update_core
// Two-wheel arc odometry pose tracker in Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_stall carries one item: cmd selects an odometry
// update (forward/sideways deltas, raw heading) or a set pose (new_x, new_y,
// new_heading). Each item gives exactly one result item on out_valid/out_stall:
// the pose after that item.
// Wheel offsets are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, as the block itself does not enforce this.
// A set pose item shows its result in the cycle after it is taken. An update
// item is stepped by the sequencer through one 34x34 multiplier: a series
// sine/cosine pass and the rotation, and, when the heading changes, first a
// series pass and the 48-step radix-2 divider that runs once per wheel axis.
// One item is in work at a time: in_stall is high from acceptance until the
// result has been taken. While out_stall holds, the result stays on the ports.
// Reset clears the pose, the heading offset and both wheel offsets.
// ----------------------------------------------------------------------------
module arc_odometry_pose_update_core
  import odo_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [0:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] forward_delta,
  input  logic signed [31:0] sideways_delta,
  input  logic signed [31:0] raw_heading,
  input  logic signed [31:0] new_x,
  input  logic signed [31:0] new_y,
  input  logic signed [31:0] new_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pose_x_out,
  output logic signed [31:0] pose_y_out,
  output logic signed [31:0] pose_heading_out
);

  odo_state_t state, state_next;

  logic signed [31:0] pose_x, pose_y, pose_heading, heading_offset;
  logic signed [31:0] fwd_off, side_off;
  logic signed [31:0] fd, sd, theta, dtheta;
  logic signed [31:0] lx, ly, sn, cs, sinv, cosv, dxr, dyr, qr;
  logic signed [32:0] k;
  logic signed [33:0] op_a, op_b;
  logic signed [67:0] prod, acc;
  logic [29:0]        x2, pr, q0r, tq;
  logic [2:0]         term;
  logic [1:0]         quad;
  logic               fold, sc_pass, axis;

  logic               in_acc;
  logic signed [31:0] theta_w, dtheta_w, half;
  logic signed [33:0] mid;
  logic [31:0]        phase;
  logic               fold_w;
  logic [30:0]        a_w;
  logic [30:0]        r_w;
  logic signed [31:0] sb, cb, s_w, c_w;
  logic signed [31:0] u_w, l_w;
  logic signed [67:0] rdiff, rsum, dsh, ssh, lsh;
  logic               div_start, div_done;
  logic signed [31:0] div_num, div_quo;

  assign prod     = op_a * op_b;
  assign in_acc   = in_valid && !in_stall;
  assign theta_w  = raw_heading + heading_offset;
  assign dtheta_w = theta_w - pose_heading;
  assign half     = dtheta >>> 1;
  assign mid      = 34'(pose_heading) + 34'(half);
  assign phase    = prod[47:16];
  assign fold_w   = phase[29:0] > EIGHTH_TURN;
  assign a_w      = fold_w ? 31'h4000_0000 - {1'b0, phase[29:0]} : {1'b0, phase[29:0]};
  assign r_w      = {1'b0, pr} - prod[30:0];
  assign u_w      = sat32(40'(qr) + 40'(axis ? side_off : fwd_off));
  assign lsh      = prod >>> 30;
  assign l_w      = sat32(lsh[39:0]);
  assign rdiff    = acc - prod;
  assign rsum     = acc + prod;
  assign dsh      = rdiff >>> 30;
  assign ssh      = rsum >>> 30;

  always_comb begin
    sb = fold ? cs : sn;
    cb = fold ? sn : cs;
    case (quad)
      2'd0: begin
        s_w = sb;
        c_w = cb;
      end
      2'd1: begin
        s_w = cb;
        c_w = -sb;
      end
      2'd2: begin
        s_w = -sb;
        c_w = -cb;
      end
      default: begin
        s_w = -cb;
        c_w = sb;
      end
    endcase
  end

  odo_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dtheta),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_acc) state_next = cmd ? ST_DONE : ST_PREP;
      ST_PREP:     state_next = ST_SC_PHASE;
      ST_SC_PHASE: state_next = ST_SC_X;
      ST_SC_X:     state_next = ST_SC_X2;
      ST_SC_X2:    state_next = ST_SC_TERM;
      ST_SC_TERM:  state_next = ST_SC_RECIP;
      ST_SC_RECIP: state_next = ST_SC_CORR;
      ST_SC_CORR:  state_next = ST_SC_ACC;
      ST_SC_ACC:   state_next = (term == 3'd7) ? ST_SC_END : ST_SC_TERM;
      ST_SC_END:   state_next = sc_pass ? ST_ROT1 : ST_DIV;
      ST_DIV:      if (div_done) state_next = ST_CH_U;
      ST_CH_U:     state_next = ST_CH_L;
      ST_CH_L:     state_next = axis ? ST_SC_PHASE : ST_DIV;
      ST_ROT1:     state_next = ST_ROT2;
      ST_ROT2:     state_next = ST_ROT3;
      ST_ROT3:     state_next = ST_ROT4;
      ST_ROT4:     state_next = ST_ROT5;
      ST_ROT5:     state_next = ST_ROT6;
      ST_ROT6:     state_next = ST_DONE;
      ST_DONE:     if (!out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    out_valid = (state == ST_DONE);
    div_start = ((state == ST_SC_END) && !sc_pass) || ((state == ST_CH_L) && !axis);
    div_num   = (state == ST_CH_L) ? sd : fd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_off  <= '0;
      side_off <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FWD_OFFSET:  fwd_off  <= cfg_data;
        CFG_SIDE_OFFSET: side_off <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x         <= '0;
      pose_y         <= '0;
      pose_heading   <= '0;
      heading_offset <= '0;
    end else if (state == ST_IDLE && in_acc && cmd) begin
      heading_offset <= heading_offset + (new_heading - pose_heading);
      pose_x         <= new_x;
      pose_y         <= new_y;
      pose_heading   <= new_heading;
    end else if (state == ST_ROT6) begin
      pose_x       <= sat32(40'(pose_x) + 40'(dxr));
      pose_y       <= sat32(40'(pose_y) + 40'(dyr));
      pose_heading <= theta;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        fd     <= forward_delta;
        sd     <= sideways_delta;
        theta  <= theta_w;
        dtheta <= dtheta_w;
      end
      ST_PREP: begin
        op_b <= TURN_K;
        axis <= 1'b0;
        if (dtheta == '0) begin
          lx      <= fd;
          ly      <= sd;
          sc_pass <= 1'b1;
          op_a    <= mid;
        end else begin
          sc_pass <= 1'b0;
          op_a    <= 34'(half);
        end
      end
      ST_SC_PHASE: begin
        quad <= phase[31:30];
        fold <= fold_w;
        op_a <= 34'(a_w);
        op_b <= HALF_PI_Q30;
      end
      ST_SC_X: begin
        sn   <= 32'(prod[59:30]);
        op_a <= 34'(prod[59:30]);
        op_b <= 34'(prod[59:30]);
      end
      ST_SC_X2: begin
        x2   <= prod[59:30];
        op_b <= 34'(prod[59:30]);
        term <= '0;
      end
      ST_SC_TERM: begin
        pr   <= prod[59:30];
        op_a <= 34'(prod[59:30]);
        op_b <= 34'(term_recip(term));
      end
      ST_SC_RECIP: begin
        q0r  <= prod[61:32];
        op_a <= 34'(prod[61:32]);
        op_b <= 34'(term_div(term));
      end
      ST_SC_CORR: begin
        tq <= (r_w >= 31'(term_div(term))) ? q0r + 30'd1 : q0r;
      end
      ST_SC_ACC: begin
        if (!term[2]) begin
          sn <= term[0] ? sn + 32'(tq) : sn - 32'(tq);
        end else begin
          cs <= term[0] ? cs + 32'(tq) : cs - 32'(tq);
        end
        op_b <= 34'(x2);
        term <= term + 3'd1;
        if (term == 3'd3) begin
          cs   <= 32'(ONE_Q30);
          op_a <= ONE_Q30;
        end else begin
          op_a <= 34'(tq);
        end
      end
      ST_SC_END: begin
        sinv <= s_w;
        cosv <= c_w;
        if (!sc_pass) begin
          k <= {s_w, 1'b0};
        end
      end
      ST_DIV: begin
        if (div_done) begin
          qr <= div_quo;
        end
      end
      ST_CH_U: begin
        op_a <= 34'(u_w);
        op_b <= 34'(k);
      end
      ST_CH_L: begin
        if (!axis) begin
          lx   <= l_w;
          axis <= 1'b1;
        end else begin
          ly      <= l_w;
          sc_pass <= 1'b1;
          op_a    <= mid;
          op_b    <= TURN_K;
        end
      end
      ST_ROT1: begin
        op_a <= 34'(lx);
        op_b <= 34'(cosv);
      end
      ST_ROT2: begin
        acc  <= prod;
        op_a <= 34'(ly);
        op_b <= 34'(sinv);
      end
      ST_ROT3: begin
        dxr  <= sat32(dsh[39:0]);
        op_a <= 34'(lx);
        op_b <= 34'(sinv);
      end
      ST_ROT4: begin
        acc  <= prod;
        op_a <= 34'(ly);
        op_b <= 34'(cosv);
      end
      ST_ROT5: begin
        dyr <= sat32(ssh[39:0]);
      end
      ST_ROT6: ;
      ST_DONE: ;
      default: ;
    endcase
  end

  assign pose_x_out       = pose_x;
  assign pose_y_out       = pose_y;
  assign pose_heading_out = pose_heading;

endmodule

// ----- hdl/odo_chk.sv -----
// ----------------------------------------------------------------------------
// odo_chk
// Port-level checks for the arc odometry pose core, bound to the top level.
// ----------------------------------------------------------------------------
module odo_chk
  import odo_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               cmd,
  input logic signed [31:0] new_x,
  input logic signed [31:0] new_y,
  input logic signed [31:0] new_heading,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] pose_x_out,
  input logic signed [31:0] pose_y_out,
  input logic signed [31:0] pose_heading_out
);

  // an accepted item closes the input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after an item was taken");

  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open while a result waits");

  a_set_pose: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && cmd |=> out_valid && pose_x_out == $past(new_x) &&
      pose_y_out == $past(new_y) && pose_heading_out == $past(new_heading))
    else $error("set pose result wrong");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pose_x_out) &&
      $stable(pose_y_out) && $stable(pose_heading_out))
    else $error("stalled result changed");

endmodule

bind arc_odometry_pose_update_core odo_chk u_odo_chk (.*);

// ----- verif/arc_odometry_pose_update_core_tb.sv -----
// ----------------------------------------------------------------------------
// arc_odometry_pose_update_core_tb
// Self-checking bench for the arc odometry pose core: drives update and set
// pose items under several wheel offset settings and idle/stall patterns, and
// compares every pose result with a bit-exact Q16.16 predictor.
// ----------------------------------------------------------------------------
class pose_scoreboard;
  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] h;
  } pose_t;

  longint fwd_offs, side_offs;
  longint px, py, ph, hoffs;
  pose_t  pending[$];
  int     errors, checked, n_upd, n_set;

  function new();
    fwd_offs = 0; side_offs = 0; px = 0; py = 0; ph = 0; hoffs = 0;
    errors = 0; checked = 0; n_upd = 0; n_set = 0;
  endfunction

  function longint wrap32(longint v);
    logic signed [31:0] w;
    w = v[31:0];
    return longint'(w);
  endfunction

  function longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function void set_offset(odo_pkg::odo_cfg_t idx, logic [31:0] val);
    if (idx == odo_pkg::CFG_FWD_OFFSET) fwd_offs = wrap32(longint'(val));
    else side_offs = wrap32(longint'(val));
  endfunction

  function void sin_cos_q30(longint ang, output longint s, output longint c);
    longint p, f, a, x, x2, t, sn, cs, sb, cb;
    logic [31:0] phase;
    logic [1:0] quad;
    logic fold;
    p = ang * 64'sd683565276;
    phase = p[47:16];
    quad = phase[31:30];
    f = longint'(phase[29:0]);
    fold = f > 64'sh2000_0000;
    a = fold ? (64'sd1073741824 - f) : f;
    x = (a * 64'sd1686629713) >>> 30;
    x2 = (x * x) >>> 30;
    t = x; sn = x;
    t = ((t * x2) >>> 30) / 6;  sn -= t;
    t = ((t * x2) >>> 30) / 20; sn += t;
    t = ((t * x2) >>> 30) / 42; sn -= t;
    t = ((t * x2) >>> 30) / 72; sn += t;
    t = 64'sd1073741824; cs = t;
    t = ((t * x2) >>> 30) / 2;  cs -= t;
    t = ((t * x2) >>> 30) / 12; cs += t;
    t = ((t * x2) >>> 30) / 30; cs -= t;
    t = ((t * x2) >>> 30) / 56; cs += t;
    sb = fold ? cs : sn;
    cb = fold ? sn : cs;
    case (quad)
      2'd0: begin s = sb;  c = cb;  end
      2'd1: begin s = cb;  c = -sb; end
      2'd2: begin s = -sb; c = -cb; end
      default: begin s = -cb; c = sb; end
    endcase
  endfunction

  function longint chord(longint delta, longint dth, longint offs, longint k);
    longint q, u;
    q = clamp32((delta * 65536) / dth);
    u = clamp32(q + offs);
    return clamp32((k * u) >>> 30);
  endfunction

  function void note_input(logic is_set, logic signed [31:0] fd, logic signed [31:0] sd,
                           logic signed [31:0] rh, logic signed [31:0] nx,
                           logic signed [31:0] ny, logic signed [31:0] nh);
    longint theta, dth, half, lx, ly, s, c, hs, hc;
    pose_t e;
    if (is_set) begin
      hoffs = wrap32(hoffs + wrap32(longint'(nh) - ph));
      px = nx; py = ny; ph = nh;
      n_set++;
    end else begin
      theta = wrap32(longint'(rh) + hoffs);
      dth = wrap32(theta - ph);
      half = dth >>> 1;
      if (dth == 0) begin
        lx = fd; ly = sd;
      end else begin
        sin_cos_q30(half, hs, hc);
        lx = chord(fd, dth, fwd_offs, 2 * hs);
        ly = chord(sd, dth, side_offs, 2 * hs);
      end
      sin_cos_q30(ph + half, s, c);
      px = clamp32(px + clamp32((lx * c - ly * s) >>> 30));
      py = clamp32(py + clamp32((lx * s + ly * c) >>> 30));
      ph = theta;
      n_upd++;
    end
    e.x = px[31:0]; e.y = py[31:0]; e.h = ph[31:0];
    pending.push_back(e);
  endfunction

  function void check_result(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] h);
    pose_t e;
    if (pending.size() == 0) begin
      $error("unexpected result x=%0d y=%0d heading=%0d", x, y, h);
      errors++;
      return;
    end
    e = pending.pop_front();
    checked++;
    if (x !== e.x) begin
      $error("pose_x_out expected %0d got %0d", e.x, x); errors++;
    end
    if (y !== e.y) begin
      $error("pose_y_out expected %0d got %0d", e.y, y); errors++;
    end
    if (h !== e.h) begin
      $error("pose_heading_out expected %0d got %0d", e.h, h); errors++;
    end
  endfunction
endclass

module arc_odometry_pose_update_core_tb;
  import odo_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic cmd = 0;
  logic signed [31:0] forward_delta = 0, sideways_delta = 0, raw_heading = 0;
  logic signed [31:0] new_x = 0, new_y = 0, new_heading = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] pose_x_out, pose_y_out, pose_heading_out;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_SET    = 1'b1;
  localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;

  pose_scoreboard sb = new();
  int send_idle = 0;
  int recv_stall = 0;
  bit hold_off = 0;

  arc_odometry_pose_update_core u_top (.*);

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(pose_x_out, pose_y_out, pose_heading_out);
    out_stall <= hold_off || ($urandom_range(99) < recv_stall);
  end

  task automatic send_item(logic c, logic signed [31:0] fd, logic signed [31:0] sd,
                           logic signed [31:0] rh, logic signed [31:0] nx,
                           logic signed [31:0] ny, logic signed [31:0] nh);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    cmd <= c; forward_delta <= fd; sideways_delta <= sd; raw_heading <= rh;
    new_x <= nx; new_y <= ny; new_heading <= nh;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note_input(c, fd, sd, rh, nx, ny, nh);
  endtask

  task automatic update(logic signed [31:0] fd, sd, rh);
    send_item(CMD_UPDATE, fd, sd, rh, $urandom, $urandom, $urandom);
  endtask

  task automatic set_pose(logic signed [31:0] nx, ny, nh);
    send_item(CMD_SET, $urandom, $urandom, $urandom, nx, ny, nh);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_offset(odo_cfg_t idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.set_offset(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_small(int span);
    return $signed($urandom_range(2 * span)) - span;
  endfunction

  // mostly plausible motion, some full-range noise and pose resets
  task automatic random_items(int n);
    logic signed [31:0] rh;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      rh = 32'(sb.ph - sb.hoffs);
      if (k < 60) begin
        if ($urandom_range(3) == 0) update(rand_small(200000), rand_small(200000), rh);
        else update(rand_small(200000), rand_small(200000), rh + rand_small(40000));
      end else if (k < 80) begin
        update(rand_small(8000000), rand_small(8000000), rh + rand_small(2000000));
      end else if (k < 92) begin
        update($urandom, $urandom, $urandom);
      end else begin
        if ($urandom_range(1)) set_pose($urandom, $urandom, $urandom);
        else set_pose(rand_small(50000000), rand_small(50000000), rand_small(800000));
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: straight moves, extremes, wraps, saturation, set pose
    update(32'sd65536, 32'sd0, 32'sd0);
    update(QMAX, QMIN, 32'sd0);
    update(QMIN, QMAX, 32'sd0);
    update(32'sd65536, 32'sd32768, 32'sd1);
    update(32'sd65536, -32'sd65536, -32'sd1);
    update(32'sd100000, 32'sd5000, 32'sd102944);
    update(QMAX, QMAX, QMAX);
    update(QMIN, QMIN, QMIN);
    update(32'sd0, 32'sd0, 32'sd0);
    set_pose(QMAX, QMAX, 32'sd0);
    update(QMAX, QMAX, 32'sd0);
    set_pose(QMIN, QMIN, QMAX);
    update(QMIN, QMIN, QMAX);
    update(32'sd1000, -32'sd1000, QMIN);
    set_pose(32'sd0, 32'sd0, 32'sd205887);
    update(32'sd65536, 32'sd65536, 32'sd0);
    update(32'sd65536, 32'sd0, 32'sd411775);
    set_pose(-32'sd1, 32'sd1, QMIN);
    update(32'sd12345, -32'sd54321, 32'sd3);
    drain();

    write_offset(CFG_FWD_OFFSET, 32'sd163840);
    write_offset(CFG_SIDE_OFFSET, -32'sd98304);
    update(32'sd65536, 32'sd65536, 32'sd1000);
    update(QMAX, QMIN, 32'sd2);
    random_items(300);
    drain();

    send_idle = 61;
    write_offset(CFG_FWD_OFFSET, QMAX);
    write_offset(CFG_SIDE_OFFSET, QMIN);
    random_items(300);
    drain();

    send_idle = 0; recv_stall = 61;
    write_offset(CFG_FWD_OFFSET, QMIN);
    write_offset(CFG_SIDE_OFFSET, QMAX);
    random_items(300);
    drain();

    send_idle = 12; recv_stall = 12;
    write_offset(CFG_FWD_OFFSET, $urandom);
    write_offset(CFG_SIDE_OFFSET, $urandom);
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      random_items(350);
    join
    drain();

    send_idle = 0; recv_stall = 0;
    write_offset(CFG_FWD_OFFSET, 32'sd0);
    write_offset(CFG_SIDE_OFFSET, 32'sd0);
    random_items(350);
    drain();

    $display("Covered %0d updates and %0d set pose items, %0d results checked,",
             sb.n_upd, sb.n_set, sb.checked);
    $display("over six wheel offset settings and mixed idle/stall phases.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
